// ===== rtl/message_rate_regulator_assert.svh =====
// Assertion macros used by the message rate regulator top level.
`ifndef MESSAGE_RATE_REGULATOR_ASSERT_SVH
`define MESSAGE_RATE_REGULATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MRR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("message_rate_regulator: check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("message_rate_regulator: check failed");

`endif

// ===== rtl/mrr_pkg.sv =====
// Package: shared constants, result codes and control/status structs.
package mrr_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int PERIOD_W  = 16;
    localparam int MSG_W     = 8;
    localparam int STATUS_W  = 3;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [PADDR_W-1:0]  ADDR_RELEASE_PERIOD = 2'd0;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELIVER  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STANDBY  = 3'd5;

    // Action codes
    localparam logic ACT_MSG  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic capture;     // latch the accepted word
        logic commit;      // apply the event to the state
        logic fetch_load;  // load the released byte into the output register
    } mrr_cmd_t;

    typedef struct packed {
        logic out_busy;    // output register holds an untaken word
        logic pop;         // pending event releases a byte from the ring
    } mrr_stat_t;

endpackage

// ===== rtl/mrr_ctrl.sv =====
// Controller: sequences accept and execute steps for each word, and a ring-fetch step on a release.
module mrr_ctrl
    import mrr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_ready,
    input  mrr_stat_t stat,
    output mrr_cmd_t  cmd,
    output logic      in_ready
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_FETCH = 3'b100
    } mrr_state_t;

    mrr_state_t state_reg;
    mrr_state_t state_next;
    logic       out_free;

    assign out_free = !stat.out_busy || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        cmd.fetch_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = stat.pop ? S_FETCH : S_IDLE;
                end
            end
            S_FETCH:
            begin
                cmd.fetch_load = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/mrr_datapath.sv =====
// Datapath: standby flag, countdown, ring buffer and output register.
module mrr_datapath
    import mrr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mrr_cmd_t            cmd,
    output mrr_stat_t           stat,
    input  logic                action,
    input  logic [MSG_W-1:0]    msg,
    input  logic [PERIOD_W-1:0] period,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] status,
    output logic [MSG_W-1:0]    msg_out
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [MSG_W-1:0]    mem [DEPTH];

    logic                act_reg;
    logic [MSG_W-1:0]    msg_reg;
    logic                standby_reg;
    logic [PERIOD_W-1:0] countdown_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [MSG_W-1:0]    rd_data_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [MSG_W-1:0]    msg_out_reg;

    logic [PTR_W-1:0]    wr_ptr_inc;
    logic [PTR_W-1:0]    rd_ptr_inc;
    logic [PERIOD_W-1:0] arm_value;
    logic                ring_empty;
    logic                ring_full;
    logic                expire;
    logic                do_write;
    logic [STATUS_W-1:0] commit_status;
    logic                out_load;

    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign arm_value  = (period == '0) ? PERIOD_W'(1) : period;
    assign ring_empty = (rd_ptr_reg == wr_ptr_reg);
    assign ring_full  = (wr_ptr_inc == rd_ptr_reg);
    assign expire     = (act_reg == ACT_TICK) && (countdown_reg == PERIOD_W'(1));
    assign do_write   = cmd.commit && (act_reg == ACT_MSG) && !standby_reg && !ring_full;

    assign stat.pop      = expire && !ring_empty;
    assign stat.out_busy = out_valid_reg;

    always_comb
    begin
        commit_status = ST_IDLE;
        if (act_reg == ACT_MSG)
        begin
            if (standby_reg)
                commit_status = ST_DELIVER;
            else if (ring_full)
                commit_status = ST_DROPPED;
            else
                commit_status = ST_QUEUED;
        end
        else if (expire)
        begin
            commit_status = ring_empty ? ST_STANDBY : ST_RELEASED;
        end
    end

    assign out_load = (cmd.commit && !stat.pop) || cmd.fetch_load;

    // ring storage: one write port, registered read at the head
    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[wr_ptr_reg] <= msg_reg;
        rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            msg_reg <= msg;
        end
        if (out_load)
        begin
            status_reg  <= cmd.fetch_load ? ST_RELEASED : commit_status;
            msg_out_reg <= cmd.fetch_load ? rd_data_reg :
                           (commit_status == ST_DELIVER) ? msg_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            standby_reg   <= 1'b1;
            countdown_reg <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                if (act_reg == ACT_MSG)
                begin
                    if (standby_reg)
                    begin
                        standby_reg   <= 1'b0;
                        countdown_reg <= arm_value;
                    end
                    else if (!ring_full)
                    begin
                        wr_ptr_reg <= wr_ptr_inc;
                    end
                end
                else if (countdown_reg != '0)
                begin
                    if (expire && !ring_empty)
                    begin
                        rd_ptr_reg    <= rd_ptr_inc;
                        countdown_reg <= arm_value;
                    end
                    else
                    begin
                        countdown_reg <= countdown_reg - 1'b1;
                        if (expire)
                            standby_reg <= 1'b1;
                    end
                end
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign msg_out   = msg_out_reg;

endmodule

// ===== rtl/message_rate_regulator.sv =====
// Top level: rate regulator with APB-style register port and valid/ready channels.
//
//   channel  signals                         direction  word
//   in       in_valid/in_ready, action, msg  to block   one event (arrival or tick)
//   out      out_valid/out_ready, status,    from block one result per event
//            msg_out
//   apb      psel/penable/pwrite/paddr/      to block   release_period at 0x0
//            pwdata/prdata/pready
//
// Each event passes through accept and execute; a tick that releases a byte from the
// ring adds a fetch step, which takes the byte from the registered read of the ring memory.
// The next word is accepted as soon as the sequencer returns to idle.
// Reset (rst_n low) empties the ring, sets standby, disarms the countdown and
// restores release_period to 1000; ring contents are left as they are.
// A result waits in the output register; while it is not taken a new word is still
// accepted, but its execute step holds until the output register frees up.
module message_rate_regulator
    import mrr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    // event input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic [MSG_W-1:0]    msg,
    // result output channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [MSG_W-1:0]    msg_out,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [PERIOD_W-1:0] period_reg;
    logic                cfg_write;
    mrr_cmd_t            cmd;
    mrr_stat_t           stat;

    // Register port: zero wait states, single register at address zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_write && (paddr == ADDR_RELEASE_PERIOD))
        begin
            // keep the low half; the new period applies at the next arming
            period_reg <= pwdata[PERIOD_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_RELEASE_PERIOD)
            prdata = PDATA_W'(period_reg);
    end

    // Sequencer: accept, execute, and fetch from the ring on a release.
    mrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (in_ready)
    );

    // Datapath: standby flag, countdown, ring buffer and result register.
    mrr_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .action    (action),
        .msg       (msg),
        .period    (period_reg),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .status    (status),
        .msg_out   (msg_out)
    );

`include "message_rate_regulator_assert.svh"

    // an accepted word keeps the sequencer busy in the following cycle
    `MRR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // only defined result codes leave the block
    `MRR_ASSERT_NOW(a_status_code, out_valid, status <= ST_STANDBY)
    // a byte travels only with a delivery or a release
    `MRR_ASSERT_NOW(a_msg_zero, out_valid && (status != ST_DELIVER) && (status != ST_RELEASED), msg_out == '0)
    // a write to the period register lands on the next cycle
    `MRR_ASSERT_NEXT(a_period_write, cfg_write && (paddr == ADDR_RELEASE_PERIOD), period_reg == $past(pwdata[PERIOD_W-1:0]))

endmodule
